// File: hw/rtl/tsad_pkg.sv
// shared types and constants for the transport stream audio demultiplexer
package tsad_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h47;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_PAT   = 2'd1;
    localparam logic [1:0] KIND_PMT   = 2'd2;
    localparam logic [1:0] KIND_AUDIO = 2'd3;

    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_MP3     = 2'd1;
    localparam logic [1:0] FMT_AAC     = 2'd2;

    localparam logic [7:0] STYPE_MP3      = 8'h04;
    localparam logic [7:0] STYPE_AAC_ADTS = 8'h0F;
    localparam logic [7:0] STYPE_AAC_LATM = 8'h11;

    localparam logic [7:0] STREAM_ID_LO = 8'hC0;
    localparam logic [7:0] STREAM_ID_HI = 8'hDF;

    localparam logic [12:0] PAT_PID = 13'd0;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] audio_byte;
        logic [1:0] audio_format;
        logic       stream_error;
        logic       packet_end;
    } tsad_result_t;

endpackage

// File: hw/rtl/tsad_parser.sv
// packet framing, table capture and payload extraction, one byte per request
module tsad_parser
    import tsad_pkg::*;
#(
    parameter int PACKET_BYTES = 188,
    parameter int MAX_PROGRAMS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [7:0]   ts_byte,
    output tsad_result_t res
);

    localparam int POS_W   = $clog2(PACKET_BYTES);
    localparam int COUNT_W = $clog2(MAX_PROGRAMS + 1);
    localparam int IDX_W   = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;

    logic               sync_found_reg, sync_found_next;
    logic [POS_W-1:0]   byte_position_reg, byte_position_next;
    logic [12:0]        packet_pid_reg, packet_pid_next;
    logic               unit_start_reg, unit_start_next;
    logic               adaptation_present_reg, adaptation_present_next;
    logic [7:0]         payload_offset_reg, payload_offset_next;
    logic [1:0]         packet_kind_reg, packet_kind_next;
    logic [12:0]        program_map_pids_reg [MAX_PROGRAMS];
    logic [COUNT_W-1:0] program_map_count_reg, program_map_count_next;
    logic [12:0]        audio_pid_reg, audio_pid_next;
    logic               audio_pid_valid_reg, audio_pid_valid_next;
    logic [1:0]         format_found_reg, format_found_next;
    logic [11:0]        section_length_reg, section_length_next;
    logic [11:0]        entry_cursor_reg, entry_cursor_next;
    logic [7:0]         entry_stream_type_reg, entry_stream_type_next;
    logic [12:0]        entry_pid_reg, entry_pid_next;
    logic [8:0]         pes_data_start_reg, pes_data_start_next;
    logic               error_flag_reg, error_flag_next;

    logic               pm_we;
    logic [12:0]        pm_wdata;
    logic [12:0]        pid_cand;
    logic               pmt_hit;

    // program-map pid lookup across the captured list
    always_comb
    begin
        pid_cand = {packet_pid_reg[12:8], ts_byte};
        pmt_hit  = 1'b0;
        for (int i = 0; i < MAX_PROGRAMS; i++)
        begin
            if ((COUNT_W'(i) < program_map_count_reg) && (program_map_pids_reg[i] == pid_cand))
            begin
                pmt_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [POS_W-1:0] pos;
        logic [8:0]       pos9;
        logic [8:0]       sum9;
        logic [7:0]       po_eff;
        logic [8:0]       ps;
        logic [8:0]       r;
        logic [8:0]       start;
        logic [12:0]      s13;
        logic [11:0]      d12;
        logic [12:0]      pid_new;
        logic [16:0]      s17;
        logic [8:0]       p;
        logic             err_eff;
        logic [8:0]       pds_eff;
        logic             valid;
        logic [7:0]       data;
        logic             pend;

        sync_found_next         = sync_found_reg;
        byte_position_next      = byte_position_reg;
        packet_pid_next         = packet_pid_reg;
        unit_start_next         = unit_start_reg;
        adaptation_present_next = adaptation_present_reg;
        payload_offset_next     = payload_offset_reg;
        packet_kind_next        = packet_kind_reg;
        program_map_count_next  = program_map_count_reg;
        audio_pid_next          = audio_pid_reg;
        audio_pid_valid_next    = audio_pid_valid_reg;
        format_found_next       = format_found_reg;
        section_length_next     = section_length_reg;
        entry_cursor_next       = entry_cursor_reg;
        entry_stream_type_next  = entry_stream_type_reg;
        entry_pid_next          = entry_pid_reg;
        pes_data_start_next     = pes_data_start_reg;
        error_flag_next         = error_flag_reg;
        pm_we    = 1'b0;
        pm_wdata = entry_pid_reg | 13'(ts_byte);
        valid    = 1'b0;
        data     = 8'd0;
        pend     = 1'b0;
        pos      = sync_found_reg ? byte_position_reg : '0;
        pos9     = 9'(pos);
        sum9     = 9'd5 + 9'(ts_byte);
        po_eff   = payload_offset_reg;
        ps       = 9'd4 + 9'(unit_start_reg);
        r        = pos9 - ps;
        start    = {r[8:2], 2'b00};
        s13      = 13'd12 + 13'(entry_cursor_reg | 12'(ts_byte));
        d12      = 12'(r) - entry_cursor_reg;
        pid_new  = entry_pid_reg | 13'(ts_byte);
        s17      = 17'(entry_cursor_reg) + 17'd5 + {1'b0, entry_stream_type_reg, ts_byte};
        p        = 9'd0;
        err_eff  = error_flag_reg;
        pds_eff  = pes_data_start_reg;

        if (sync_found_reg || (ts_byte == SYNC_BYTE))
        begin
            sync_found_next = 1'b1;
            if (pos9 == 9'd0)
            begin
                unit_start_next         = 1'b0;
                adaptation_present_next = 1'b0;
                payload_offset_next     = 8'd4;
                packet_kind_next        = KIND_OTHER;
                packet_pid_next         = 13'd0;
                pes_data_start_next     = 9'd9;
            end
            else if (pos9 == 9'd1)
            begin
                packet_pid_next = {ts_byte[4:0], 8'd0};
                unit_start_next = ts_byte[6];
            end
            else if (pos9 == 9'd2)
            begin
                packet_pid_next = pid_cand;
                if (pid_cand == PAT_PID)
                begin
                    packet_kind_next       = KIND_PAT;
                    program_map_count_next = '0;
                end
                else if (audio_pid_valid_reg && (pid_cand == audio_pid_reg))
                begin
                    packet_kind_next = KIND_AUDIO;
                end
                else if (pmt_hit)
                begin
                    packet_kind_next = KIND_PMT;
                end
                else
                begin
                    packet_kind_next = KIND_OTHER;
                end
            end
            else if (pos9 == 9'd3)
            begin
                adaptation_present_next = ts_byte[5];
                payload_offset_next     = 8'd4;
            end
            else
            begin
                if ((pos9 == 9'd4) && adaptation_present_reg)
                begin
                    po_eff              = (sum9 > 9'd255) ? 8'hFF : sum9[7:0];
                    payload_offset_next = po_eff;
                end
                if ((packet_kind_reg == KIND_PAT) && (pos9 >= ps))
                begin
                    if (r == 9'd1)
                    begin
                        section_length_next = {ts_byte[3:0], 8'd0};
                    end
                    else if (r == 9'd2)
                    begin
                        section_length_next = section_length_reg | 12'(ts_byte);
                    end
                    else if ((r >= 9'd8) && !((13'(start) + 13'd5) > 13'(section_length_reg)))
                    begin
                        if (r[1:0] == 2'd2)
                        begin
                            entry_pid_next = {ts_byte[4:0], 8'd0};
                        end
                        else if ((r[1:0] == 2'd3)
                                 && (program_map_count_reg < COUNT_W'(MAX_PROGRAMS)))
                        begin
                            pm_we                  = 1'b1;
                            program_map_count_next = program_map_count_reg + COUNT_W'(1);
                        end
                    end
                end
                else if ((packet_kind_reg == KIND_PMT) && (pos9 >= ps))
                begin
                    if (r == 9'd1)
                    begin
                        section_length_next = {ts_byte[3:0], 8'd0};
                    end
                    else if (r == 9'd2)
                    begin
                        section_length_next = section_length_reg | 12'(ts_byte);
                    end
                    else if (r == 9'd10)
                    begin
                        entry_cursor_next = {ts_byte[3:0], 8'd0};
                    end
                    else if (r == 9'd11)
                    begin
                        entry_cursor_next = (s13 > 13'd4095) ? 12'hFFF : s13[11:0];
                    end
                    else if ((r >= 9'd12) && (12'(r) >= entry_cursor_reg)
                             && !((13'(entry_cursor_reg) + 13'd1) >= 13'(section_length_reg)))
                    begin
                        case (d12)
                            12'd0:
                            begin
                                entry_stream_type_next = ts_byte;
                            end
                            12'd1:
                            begin
                                entry_pid_next = {ts_byte[4:0], 8'd0};
                            end
                            12'd2:
                            begin
                                entry_pid_next = pid_new;
                                if (entry_stream_type_reg == STYPE_MP3)
                                begin
                                    format_found_next    = FMT_MP3;
                                    audio_pid_next       = pid_new;
                                    audio_pid_valid_next = 1'b1;
                                end
                                else if ((entry_stream_type_reg == STYPE_AAC_ADTS)
                                         || (entry_stream_type_reg == STYPE_AAC_LATM))
                                begin
                                    format_found_next    = FMT_AAC;
                                    audio_pid_next       = pid_new;
                                    audio_pid_valid_next = 1'b1;
                                end
                            end
                            12'd3:
                            begin
                                entry_stream_type_next = {4'd0, ts_byte[3:0]};
                            end
                            12'd4:
                            begin
                                entry_cursor_next = (s17 > 17'd4095) ? 12'hFFF : s17[11:0];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if ((packet_kind_reg == KIND_AUDIO) && (pos9 >= 9'(po_eff)))
                begin
                    p = pos9 - 9'(po_eff);
                    if (unit_start_reg)
                    begin
                        if ((p == 9'd3)
                            && ((ts_byte < STREAM_ID_LO) || (ts_byte > STREAM_ID_HI)))
                        begin
                            err_eff = 1'b1;
                        end
                        if (p == 9'd8)
                        begin
                            pds_eff = 9'd9 + 9'(ts_byte);
                        end
                        error_flag_next     = err_eff;
                        pes_data_start_next = pds_eff;
                        if ((p >= pds_eff) && !err_eff)
                        begin
                            valid = 1'b1;
                            data  = ts_byte;
                        end
                    end
                    else if (!error_flag_reg)
                    begin
                        valid = 1'b1;
                        data  = ts_byte;
                    end
                end
            end

            if ((pos9 + 9'd1) >= 9'(PACKET_BYTES))
            begin
                byte_position_next = '0;
                pend               = 1'b1;
            end
            else
            begin
                byte_position_next = pos + POS_W'(1);
            end
        end

        res.byte_valid   = valid;
        res.audio_byte   = data;
        res.audio_format = format_found_next;
        res.stream_error = error_flag_next;
        res.packet_end   = pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_found_reg         <= 1'b0;
            byte_position_reg      <= '0;
            packet_pid_reg         <= 13'd0;
            unit_start_reg         <= 1'b0;
            adaptation_present_reg <= 1'b0;
            payload_offset_reg     <= 8'd4;
            packet_kind_reg        <= KIND_OTHER;
            program_map_count_reg  <= '0;
            audio_pid_reg          <= 13'd0;
            audio_pid_valid_reg    <= 1'b0;
            format_found_reg       <= FMT_UNKNOWN;
            section_length_reg     <= 12'd0;
            entry_cursor_reg       <= 12'd0;
            entry_stream_type_reg  <= 8'd0;
            entry_pid_reg          <= 13'd0;
            pes_data_start_reg     <= 9'd0;
            error_flag_reg         <= 1'b0;
        end
        else if (en)
        begin
            sync_found_reg         <= sync_found_next;
            byte_position_reg      <= byte_position_next;
            packet_pid_reg         <= packet_pid_next;
            unit_start_reg         <= unit_start_next;
            adaptation_present_reg <= adaptation_present_next;
            payload_offset_reg     <= payload_offset_next;
            packet_kind_reg        <= packet_kind_next;
            program_map_count_reg  <= program_map_count_next;
            audio_pid_reg          <= audio_pid_next;
            audio_pid_valid_reg    <= audio_pid_valid_next;
            format_found_reg       <= format_found_next;
            section_length_reg     <= section_length_next;
            entry_cursor_reg       <= entry_cursor_next;
            entry_stream_type_reg  <= entry_stream_type_next;
            entry_pid_reg          <= entry_pid_next;
            pes_data_start_reg     <= pes_data_start_next;
            error_flag_reg         <= error_flag_next;
        end
    end

    // program-map pid list, contents undefined until a pat fills them
    always_ff @(posedge clk)
    begin
        if (en && pm_we)
        begin
            program_map_pids_reg[program_map_count_reg[IDX_W-1:0]] <= pm_wdata;
        end
    end

endmodule

// File: hw/rtl/ts_audio_demux.sv
// transport stream audio demultiplexer top level
//
// s_axis carries one transport stream byte per request in tdata[7:0]. the
// block drops bytes until the first 0x47, then frames fixed-size packets by
// count, captures the pat and pmt, and extracts the audio elementary stream.
// m_axis returns exactly one result per input byte: tuser is byte_valid,
// tdata holds audio_byte, audio_format and stream_error, tlast marks the last
// byte of each packet.
// each result is registered: into the output register, or into the skid register while m_axis stalls.
// throughput: one byte per cycle while m_axis accepts results, set by the single registered pass of the
// parser; all field capture and compares finish in that cycle.
// reset clears sync, table state, format and the error flag; the program-map
// pid list holds no data until a pat is seen and needs no clearing pass.
// when m_axis stalls, one more byte is still taken into a skid register;
// s_axis_tready falls only while both output and skid registers are full.
module ts_audio_demux
    import tsad_pkg::*;
#(
    parameter int PACKET_BYTES = 188,
    parameter int MAX_PROGRAMS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ts_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // audio_byte[7:0], audio_format[9:8], stream_error[10]
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast
);

    tsad_result_t res;
    tsad_result_t out_reg;
    tsad_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         pop;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    tsad_parser #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_PROGRAMS (MAX_PROGRAMS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .ts_byte (s_axis_tdata),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.stream_error, out_reg.audio_format, out_reg.audio_byte};
    assign m_axis_tuser  = out_reg.byte_valid;
    assign m_axis_tlast  = out_reg.packet_end;

    // skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // stream error is sticky across delivered results
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        pop && m_axis_tdata[10] |=> !(m_axis_tvalid && !m_axis_tdata[10]))
        else $error("stream error cleared after being raised");

    // no payload is emitted once the stream error is set
    a_no_payload_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[10])
        else $error("payload byte delivered with stream error set");

    // non-payload results carry a zero data byte
    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("non-payload result carries nonzero data");

endmodule

// File: test/tb_ts_audio_demux.sv
// testbench for ts_audio_demux: directed ts packets checked against a byte-level predictor
`timescale 1ns / 1ps

module tb_ts_audio_demux;
    import tsad_pkg::*;

    localparam int PKT_LEN  = 188;
    localparam int NUM_PROG = 8;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    ts_audio_demux DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic        in_sync           = 1'b0;
    int unsigned ts_pos            = 0;
    logic [12:0] hdr_pid           = '0;
    logic        hdr_unit_start    = 1'b0;
    logic        hdr_has_adapt     = 1'b0;
    int unsigned payload_start     = 4;
    logic [1:0]  cur_kind          = KIND_OTHER;
    logic [12:0] pmt_pid_list [NUM_PROG];
    int unsigned pmt_pid_count     = 0;
    logic [12:0] es_pid            = '0;
    logic        es_pid_known      = 1'b0;
    logic [1:0]  es_format         = FMT_UNKNOWN;
    int unsigned sect_len          = 0;
    int unsigned loop_pos          = 0;
    int unsigned loop_type         = 0;
    logic [12:0] loop_pid          = '0;
    int unsigned pes_payload_start = 0;
    logic        es_error          = 1'b0;

    tsad_result_t exp_results [$];
    int           fail_count     = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           pkt_count      = 0;

    logic [7:0] pkt [PKT_LEN];
    int         tbl_start;
    int         tbl_pos;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int unsigned clamp12(input int unsigned v);
        return (v > 32'hFFF) ? 32'hFFF : v;
    endfunction

    function automatic void classify_pid();
        int unsigned i;
        cur_kind = KIND_OTHER;
        if (hdr_pid == PAT_PID)
        begin
            cur_kind = KIND_PAT;
            pmt_pid_count = 0;
        end
        else if (es_pid_known && hdr_pid == es_pid)
            cur_kind = KIND_AUDIO;
        else
            for (i = 0; i < pmt_pid_count && i < NUM_PROG; i++)
                if (pmt_pid_list[i] == hdr_pid)
                    cur_kind = KIND_PMT;
    endfunction

    function automatic void pat_section_byte(input int unsigned r, input logic [7:0] b);
        int unsigned d;
        if (r == 1)
            sect_len = {b[3:0], 8'h00};
        else if (r == 2)
            sect_len = sect_len | b;
        else if (r >= 8)
        begin
            d = (r - 8) & 3;
            if (r - d + 5 <= sect_len)
            begin
                if (d == 2)
                    loop_pid = {b[4:0], 8'h00};
                else if (d == 3 && pmt_pid_count < NUM_PROG)
                begin
                    pmt_pid_list[pmt_pid_count] = loop_pid | {5'd0, b};
                    pmt_pid_count++;
                end
            end
        end
    endfunction

    function automatic void pmt_section_byte(input int unsigned r, input logic [7:0] b);
        int unsigned d;
        if (r == 1)
            sect_len = {b[3:0], 8'h00};
        else if (r == 2)
            sect_len = sect_len | b;
        else if (r == 10)
            loop_pos = {b[3:0], 8'h00};
        else if (r == 11)
            loop_pos = clamp12(12 + (loop_pos | b));
        else if (r >= 12 && r >= loop_pos && loop_pos + 1 < sect_len)
        begin
            d = r - loop_pos;
            if (d == 0)
                loop_type = b;
            else if (d == 1)
                loop_pid = {b[4:0], 8'h00};
            else if (d == 2)
            begin
                loop_pid = loop_pid | {5'd0, b};
                if (loop_type == STYPE_MP3)
                begin
                    es_format = FMT_MP3;
                    es_pid = loop_pid;
                    es_pid_known = 1'b1;
                end
                else if (loop_type == STYPE_AAC_ADTS || loop_type == STYPE_AAC_LATM)
                begin
                    es_format = FMT_AAC;
                    es_pid = loop_pid;
                    es_pid_known = 1'b1;
                end
            end
            else if (d == 3)
                loop_type = b & 8'h0F;
            else if (d == 4)
                loop_pos = clamp12(loop_pos + 5 + ((loop_type << 8) | b));
        end
    endfunction

    function automatic tsad_result_t predict_demux(input logic [7:0] b);
        tsad_result_t r;
        int unsigned  ps;
        int unsigned  p;
        r = '0;
        if (!in_sync)
        begin
            if (b != SYNC_BYTE)
            begin
                r.audio_format = es_format;
                r.stream_error = es_error;
                return r;
            end
            in_sync = 1'b1;
            ts_pos = 0;
        end
        if (ts_pos == 0)
        begin
            hdr_unit_start = 1'b0;
            hdr_has_adapt = 1'b0;
            payload_start = 4;
            cur_kind = KIND_OTHER;
            hdr_pid = '0;
            pes_payload_start = 9;
        end
        else if (ts_pos == 1)
        begin
            hdr_pid = {b[4:0], 8'h00};
            hdr_unit_start = b[6];
        end
        else if (ts_pos == 2)
        begin
            hdr_pid[7:0] = b;
            classify_pid();
        end
        else if (ts_pos == 3)
        begin
            hdr_has_adapt = b[5];
            payload_start = 4;
        end
        else
        begin
            if (ts_pos == 4 && hdr_has_adapt)
                payload_start = (5 + b > 255) ? 255 : 5 + b;
            if (cur_kind == KIND_PAT || cur_kind == KIND_PMT)
            begin
                ps = 4 + hdr_unit_start;
                if (ts_pos >= ps)
                begin
                    if (cur_kind == KIND_PAT)
                        pat_section_byte(ts_pos - ps, b);
                    else
                        pmt_section_byte(ts_pos - ps, b);
                end
            end
            else if (cur_kind == KIND_AUDIO && ts_pos >= payload_start)
            begin
                p = ts_pos - payload_start;
                if (hdr_unit_start)
                begin
                    if (p == 3 && (b < STREAM_ID_LO || b > STREAM_ID_HI))
                        es_error = 1'b1;
                    if (p == 8)
                        pes_payload_start = 9 + b;
                    if (p >= pes_payload_start && !es_error)
                    begin
                        r.byte_valid = 1'b1;
                        r.audio_byte = b;
                    end
                end
                else if (!es_error)
                begin
                    r.byte_valid = 1'b1;
                    r.audio_byte = b;
                end
            end
        end
        if (ts_pos + 1 >= PKT_LEN)
        begin
            ts_pos = 0;
            r.packet_end = 1'b1;
        end
        else
            ts_pos = ts_pos + 1;
        r.audio_format = es_format;
        r.stream_error = es_error;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        tsad_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (exp_results.size() == 0)
            begin
                $error("result with no request pending: tdata %0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = exp_results.pop_front();
                if (m_axis_tuser !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== want.audio_byte)
                begin
                    $error("audio_byte: expected %0h, got %0h", want.audio_byte,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[9:8] !== want.audio_format)
                begin
                    $error("audio_format: expected %0d, got %0d", want.audio_format,
                           m_axis_tdata[9:8]);
                    fail_count++;
                end
                if (m_axis_tdata[10] !== want.stream_error)
                begin
                    $error("stream_error: expected %0b, got %0b", want.stream_error,
                           m_axis_tdata[10]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.packet_end)
                begin
                    $error("packet_end: expected %0b, got %0b", want.packet_end, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        exp_results.push_back(predict_demux(b));
    endtask

    task automatic send_packet();
        int i;
        case (pkt_count % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
            default: begin src_idle_pct = 38; sink_stall_pct = 38; end
        endcase
        pkt_count++;
        for (i = 0; i < PKT_LEN; i++)
            send_byte(pkt[i]);
    endtask

    function automatic void put_byte(input int idx, input logic [7:0] v);
        if (idx < PKT_LEN)
            pkt[idx] = v;
    endfunction

    // header plus random body; builders overwrite what they need
    function automatic void fill_header(input logic [12:0] p, input logic unit,
                                        input logic adapt);
        logic [7:0] r1;
        logic [7:0] r3;
        int         i;
        r1 = 8'($urandom_range(255));
        r3 = 8'($urandom_range(255));
        pkt[0] = SYNC_BYTE;
        pkt[1] = {r1[7], unit, r1[5], p[12:8]};
        pkt[2] = p[7:0];
        pkt[3] = {r3[7:6], adapt, r3[4:0]};
        for (i = 4; i < PKT_LEN; i++)
            pkt[i] = 8'($urandom_range(255));
    endfunction

    function automatic void start_pat(input logic unit);
        fill_header(PAT_PID, unit, 1'b0);
        tbl_start = 4 + unit;
        if (unit)
            pkt[4] = 8'h00;
        pkt[tbl_start] = 8'h00;
        tbl_pos = tbl_start + 8;
    endfunction

    function automatic void add_pat_entry(input logic [12:0] p);
        put_byte(tbl_pos + 2, {3'b111, p[12:8]});
        put_byte(tbl_pos + 3, p[7:0]);
        tbl_pos = tbl_pos + 4;
    endfunction

    function automatic void start_pmt(input logic [12:0] p, input logic unit,
                                      input logic adapt, input int info_len);
        fill_header(p, unit, adapt);
        tbl_start = 4 + unit;
        if (unit)
            pkt[4] = 8'h00;
        pkt[tbl_start] = 8'h02;
        pkt[tbl_start + 10] = {4'hF, info_len[11:8]};
        pkt[tbl_start + 11] = info_len[7:0];
        tbl_pos = tbl_start + 12 + info_len;
    endfunction

    function automatic void add_pmt_entry(input logic [7:0] stype, input logic [12:0] p,
                                          input int es_info_len);
        put_byte(tbl_pos, stype);
        put_byte(tbl_pos + 1, {3'b111, p[12:8]});
        put_byte(tbl_pos + 2, p[7:0]);
        put_byte(tbl_pos + 3, {4'hF, es_info_len[11:8]});
        put_byte(tbl_pos + 4, es_info_len[7:0]);
        tbl_pos = tbl_pos + 5 + es_info_len;
    endfunction

    // section length covers everything after the length field, crc included
    function automatic void close_table(input int adj);
        int sl;
        sl = tbl_pos + 4 - (tbl_start + 3) + adj;
        if (sl < 0)
            sl = 0;
        pkt[tbl_start + 1] = {4'hB, sl[11:8]};
        pkt[tbl_start + 2] = sl[7:0];
    endfunction

    function automatic void build_audio(input logic [12:0] p, input logic unit,
                                        input int adapt_len, input logic [7:0] sid,
                                        input int hdr_len);
        int idx;
        fill_header(p, unit, adapt_len >= 0);
        idx = 4;
        if (adapt_len >= 0)
        begin
            pkt[4] = adapt_len[7:0];
            idx = 5 + adapt_len;
        end
        if (unit)
        begin
            put_byte(idx, 8'h00);
            put_byte(idx + 1, 8'h00);
            put_byte(idx + 2, 8'h01);
            put_byte(idx + 3, sid);
            put_byte(idx + 6, 8'h84);
            put_byte(idx + 7, 8'h80);
            put_byte(idx + 8, hdr_len[7:0]);
        end
    endfunction

    task automatic test_pre_sync();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h46);
        send_byte(8'h48);
        send_byte(8'hB8);
    endtask

    task automatic test_tables();
        int i;
        // more entries than the list holds, the first names the pmt
        start_pat(1'b1);
        for (i = 0; i < 10; i++)
            add_pat_entry(13'h0100 + 13'(i));
        close_table(0);
        send_packet();
        // adaptation flag on a table is not skipped; later entry overrides
        start_pmt(13'h0100, 1'b1, 1'b1, 4);
        add_pmt_entry(8'h1B, 13'h0200, 3);
        add_pmt_entry(STYPE_AAC_ADTS, 13'h0201, 2);
        add_pmt_entry(STYPE_MP3, 13'h0202, 0);
        close_table(0);
        send_packet();
    endtask

    task automatic test_audio_payload();
        build_audio(13'h0202, 1'b1, 10, STREAM_ID_HI, 5);
        send_packet();
    endtask

    task automatic test_lost_sync();
        // continuation with a bad sync byte, whole payload goes out
        build_audio(13'h0202, 1'b0, -1, 8'h00, 0);
        pkt[0] = 8'h00;
        send_packet();
    endtask

    task automatic test_stream_error();
        build_audio(13'h0202, 1'b1, 2, 8'hBF, 0);
        send_packet();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pre_sync();
        test_tables();
        test_audio_payload();
        test_lost_sync();
        test_stream_error();

        s_axis_tvalid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tsad_pkg.sv
hw/rtl/tsad_parser.sv
hw/rtl/ts_audio_demux.sv
test/tb_ts_audio_demux.sv
